[rtl/pru_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pru_pkg
// Shared constants, codes and types of the PNG row unfilter unit.
// ----------------------------------------------------------------------------
package pru_pkg;

   // Line store and pixel geometry
   localparam int MAX_ROW_BYTES   = 8192;
   localparam int MAX_PIXEL_BYTES = 8;

   // Field widths fixed by the interface
   localparam int BYTE_W      = 8;
   localparam int ROW_BYTES_W = 14;
   localparam int PIX_W       = 4;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = ROW_BYTES_W;

   // Derived widths
   localparam int COL_W     = $clog2(MAX_ROW_BYTES);
   localparam int CNT_W     = COL_W + 1;
   localparam int RB_W      = (ROW_BYTES_W > CNT_W) ? ROW_BYTES_W : CNT_W;
   localparam int PIX_SEL_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_BYTES   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_BYTES = 1'b1;

   // Largest defined filter code
   localparam logic [BYTE_W-1:0] FILT_CODE_MAX = 8'd4;

   typedef enum logic [2:0] {
      FILT_NONE  = 3'd0,
      FILT_SUB   = 3'd1,
      FILT_UP    = 3'd2,
      FILT_AVG   = 3'd3,
      FILT_PAETH = 3'd4
   } filter_type;

   // Item held between the address stage and the reconstruction stage
   typedef struct packed {
      logic                is_type;
      filter_type          filter;
      logic [BYTE_W-1:0]   data;
      logic                zero_b;
      logic                row_end;
      logic [COL_W-1:0]    addr;
   } s1_item_type;

   // Line store write port
   typedef struct packed {
      logic                en;
      logic [COL_W-1:0]    addr;
      logic [BYTE_W-1:0]   data;
   } ram_wr_type;

endpackage

[rtl/pru_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pru_req_if / pru_rsp_if
// Valid/ready channels carrying filtered bytes in and raw bytes out.
// ----------------------------------------------------------------------------
interface pru_req_if;
   logic                       valid;
   logic                       ready;
   logic [pru_pkg::BYTE_W-1:0] filtered_byte;
   logic                       image_start;

   modport source (output valid, output filtered_byte, output image_start, input ready);
   modport sink   (input valid, input filtered_byte, input image_start, output ready);
endinterface

interface pru_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [pru_pkg::BYTE_W-1:0] pixel_byte;
   logic                       row_end;

   modport source (output valid, output pixel_byte, output row_end, input ready);
   modport sink   (input valid, input pixel_byte, input row_end, output ready);
endinterface

[rtl/png_row_unfilter_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png_row_unfilter_unit
// PNG scanline reconstruction (none, sub, up, average, Paeth), one byte per
// cycle while the output accepts, with the previous row held in a line store.
// ----------------------------------------------------------------------------
//  Channel    Dir  Handshake     Payload
//  req_chan   in   valid/ready   filtered_byte, image_start
//  rsp_chan   out  valid/ready   pixel_byte, row_end
//  csr_*      in   csr_we        csr_index, csr_wdata
//
//  One byte per cycle sustained while rsp is not stalled; a data byte goes
//  from acceptance through the line store read, then predictor and output register.
//  Filter type bytes produce no transaction.
//  The line store needs no clearing; reset is synchronous, active high.
//  A stalled output holds the reconstruction stage; req_chan.ready drops
//  only while that stage holds a data byte that cannot move.
// ----------------------------------------------------------------------------
module png_row_unfilter_unit (
   input  logic                               clock,
   input  logic                               reset,
   pru_req_if.sink                            req_chan,
   pru_rsp_if.source                          rsp_chan,
   input  logic                               csr_we,
   input  logic [pru_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pru_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic [pru_pkg::ROW_BYTES_W-1:0] row_bytes_ff;
   logic [pru_pkg::PIX_W-1:0]       bpp_ff;

   logic [pru_pkg::COL_W-1:0]       column_ff, column_in;
   pru_pkg::filter_type             filter_ff, filter_in;
   logic                            top_row_ff, top_row_in;
   logic                            awaiting_ff, awaiting_in;
   logic                            s1_valid_ff, s1_valid_in;
   pru_pkg::s1_item_type            s1_item_ff, s1_item_in;

   logic                            accept;
   logic                            start_type;
   logic                            top_eff;
   logic                            s1_move;
   logic [pru_pkg::RB_W-1:0]        rb_eff;
   logic [pru_pkg::RB_W-1:0]        col_next;
   logic                            row_done;
   logic [pru_pkg::PIX_W-1:0]       bpp_eff;
   logic [pru_pkg::PIX_SEL_W-1:0]   pix_sel;
   logic                            rd_en;
   logic [pru_pkg::BYTE_W-1:0]      rd_data;
   pru_pkg::ram_wr_type             wr;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         row_bytes_ff <= pru_pkg::ROW_BYTES_W'(1);
         bpp_ff       <= pru_pkg::PIX_W'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            pru_pkg::CSR_ROW_BYTES:   row_bytes_ff <= csr_wdata[pru_pkg::ROW_BYTES_W-1:0];
            pru_pkg::CSR_PIXEL_BYTES: bpp_ff       <= csr_wdata[pru_pkg::PIX_W-1:0];
            default: ;
         endcase
      end
   end

   // effective row length and pixel size
   always_comb begin
      rb_eff = pru_pkg::RB_W'(row_bytes_ff);
      if (rb_eff == '0) begin
         rb_eff = pru_pkg::RB_W'(1);
      end else if (rb_eff > pru_pkg::RB_W'(pru_pkg::MAX_ROW_BYTES)) begin
         rb_eff = pru_pkg::RB_W'(pru_pkg::MAX_ROW_BYTES);
      end
      bpp_eff = bpp_ff;
      if (bpp_eff == '0) begin
         bpp_eff = pru_pkg::PIX_W'(1);
      end else if (bpp_eff > pru_pkg::PIX_W'(pru_pkg::MAX_PIXEL_BYTES)) begin
         bpp_eff = pru_pkg::PIX_W'(pru_pkg::MAX_PIXEL_BYTES);
      end
      pix_sel = pru_pkg::PIX_SEL_W'(bpp_eff - pru_pkg::PIX_W'(1));
   end

   // address stage: row sequencing and line store read issue
   always_comb begin
      req_chan.ready = !s1_valid_ff || s1_move;
      accept         = req_chan.valid && req_chan.ready;
      start_type     = awaiting_ff || req_chan.image_start;
      top_eff        = top_row_ff || req_chan.image_start;
      col_next       = pru_pkg::RB_W'(column_ff) + pru_pkg::RB_W'(1);
      row_done       = col_next >= rb_eff;

      column_in   = column_ff;
      filter_in   = filter_ff;
      top_row_in  = top_row_ff;
      awaiting_in = awaiting_ff;

      s1_item_in.is_type = start_type;
      s1_item_in.filter  = filter_ff;
      s1_item_in.data    = req_chan.filtered_byte;
      s1_item_in.zero_b  = top_eff;
      s1_item_in.row_end = row_done;
      s1_item_in.addr    = column_ff;

      if (accept) begin
         if (start_type) begin
            filter_in   = (req_chan.filtered_byte <= pru_pkg::FILT_CODE_MAX) ?
                          pru_pkg::filter_type'(req_chan.filtered_byte[2:0]) :
                          pru_pkg::FILT_NONE;
            column_in   = '0;
            awaiting_in = 1'b0;
            top_row_in  = top_eff;
         end else if (row_done) begin
            column_in   = '0;
            top_row_in  = 1'b0;
            awaiting_in = 1'b1;
         end else begin
            column_in   = pru_pkg::COL_W'(col_next);
         end
      end

      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      rd_en = accept && !start_type;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff   <= '0;
         filter_ff   <= pru_pkg::FILT_NONE;
         top_row_ff  <= 1'b1;
         awaiting_ff <= 1'b1;
         s1_valid_ff <= 1'b0;
      end else begin
         column_ff   <= column_in;
         filter_ff   <= filter_in;
         top_row_ff  <= top_row_in;
         awaiting_ff <= awaiting_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= s1_item_in;
      end
   end

   // row above
   pru_line_ram u_line_ram (
      .clock   (clock),
      .wr      (wr),
      .rd_en   (rd_en),
      .rd_addr (column_ff),
      .rd_data (rd_data)
   );

   // predictor and output
   pru_recon u_recon (
      .clock    (clock),
      .reset    (reset),
      .s1_valid (s1_valid_ff),
      .s1_item  (s1_item_ff),
      .rd_data  (rd_data),
      .pix_sel  (pix_sel),
      .s1_move  (s1_move),
      .wr       (wr),
      .rsp_chan (rsp_chan)
   );

   // a write-back never hits the column being read in the same cycle
   assert property (@(posedge clock) disable iff (reset)
      (wr.en && rd_en) |-> (wr.addr != column_ff))
      else $error("line store read and write collide");

   // a new output transaction comes only from a data byte in the stage
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(s1_valid_ff && !s1_item_ff.is_type))
      else $error("output without a data byte");

   // input back-pressure only while the stage is occupied
   assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (s1_valid_ff && !s1_item_ff.is_type && rsp_chan.valid))
      else $error("input stalled without cause");

endmodule

[rtl/pru_line_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pru_line_ram
// Line store for the row above: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pru_line_ram (
   input  logic                              clock,
   input  pru_pkg::ram_wr_type               wr,
   input  logic                              rd_en,
   input  logic [pru_pkg::COL_W-1:0]         rd_addr,
   output logic [pru_pkg::BYTE_W-1:0]        rd_data
);

   logic [pru_pkg::BYTE_W-1:0] mem [pru_pkg::MAX_ROW_BYTES];
   logic [pru_pkg::BYTE_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/pru_recon.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pru_recon
// Reconstruction stage: predictor, left/upper-left history, line store
// write-back and the output register.
// ----------------------------------------------------------------------------
module pru_recon (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              s1_valid,
   input  pru_pkg::s1_item_type              s1_item,
   input  logic [pru_pkg::BYTE_W-1:0]        rd_data,
   input  logic [pru_pkg::PIX_SEL_W-1:0]     pix_sel,
   output logic                              s1_move,
   output pru_pkg::ram_wr_type               wr,
   pru_rsp_if.source                         rsp_chan
);

   logic [pru_pkg::BYTE_W-1:0] left_ff [pru_pkg::MAX_PIXEL_BYTES];
   logic [pru_pkg::BYTE_W-1:0] uleft_ff [pru_pkg::MAX_PIXEL_BYTES];
   logic                       out_valid_ff;
   logic [pru_pkg::BYTE_W-1:0] out_byte_ff;
   logic                       out_end_ff;

   logic [pru_pkg::BYTE_W-1:0] a, b, c, pred, x;
   logic [pru_pkg::BYTE_W:0]   ab_sum;
   logic signed [9:0]          pa, pb, pc;
   logic                       out_free;
   logic                       data_move;
   logic                       type_move;

   function automatic logic signed [9:0] abs10(input logic signed [9:0] v);
      abs10 = (v < 0) ? -v : v;
   endfunction

   // neighbors
   always_comb begin
      a = left_ff[pix_sel];
      c = uleft_ff[pix_sel];
      b = s1_item.zero_b ? '0 : rd_data;
   end

   // predictor
   always_comb begin
      ab_sum = {1'b0, a} + {1'b0, b};
      pa = abs10($signed({2'b00, b}) - $signed({2'b00, c}));
      pb = abs10($signed({2'b00, a}) - $signed({2'b00, c}));
      pc = abs10($signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0}));
      unique case (s1_item.filter)
         pru_pkg::FILT_SUB:   pred = a;
         pru_pkg::FILT_UP:    pred = b;
         pru_pkg::FILT_AVG:   pred = ab_sum[pru_pkg::BYTE_W:1];
         pru_pkg::FILT_PAETH: begin
            if (pa <= pb && pa <= pc) begin
               pred = a;
            end else if (pb <= pc) begin
               pred = b;
            end else begin
               pred = c;
            end
         end
         default:             pred = '0;
      endcase
      x = s1_item.data + pred;
   end

   // stage handshake: type bytes leave freely, data bytes need output room
   always_comb begin
      out_free  = !out_valid_ff || rsp_chan.ready;
      s1_move   = s1_valid && (s1_item.is_type || out_free);
      data_move = s1_move && !s1_item.is_type;
      type_move = s1_move && s1_item.is_type;
   end

   // line store write-back
   always_comb begin
      wr.en   = data_move;
      wr.addr = s1_item.addr;
      wr.data = x;
   end

   // left and upper-left history, newest first
   always_ff @(posedge clock) begin
      if (reset || type_move) begin
         for (int k = 0; k < pru_pkg::MAX_PIXEL_BYTES; k++) begin
            left_ff[k]  <= '0;
            uleft_ff[k] <= '0;
         end
      end else if (data_move) begin
         for (int k = pru_pkg::MAX_PIXEL_BYTES - 1; k > 0; k--) begin
            left_ff[k]  <= left_ff[k-1];
            uleft_ff[k] <= uleft_ff[k-1];
         end
         left_ff[0]  <= x;
         uleft_ff[0] <= b;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (data_move) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (data_move) begin
         out_byte_ff <= x;
         out_end_ff  <= s1_item.row_end;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.pixel_byte = out_byte_ff;
   assign rsp_chan.row_end    = out_end_ff;

endmodule
